FILE: design/bounded_list_with_middle_ops_core_defines.svh
// ---------------------------------------------------------------------------
// bounded list core assertion macros
// shared property forms for the list core checks
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIST_WITH_MIDDLE_OPS_CORE_DEFINES_SVH
`define BOUNDED_LIST_WITH_MIDDLE_OPS_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BLMO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blmo same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BLMO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blmo next-cycle check failed");

`endif

FILE: design/blmo_pkg.sv
// ---------------------------------------------------------------------------
// blmo_pkg
// types and constants of the bounded list core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package blmo_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 5;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 2;
  localparam int S_DATA_W     = 40;
  localparam int M_DATA_W     = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_MID   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_POP_MID    = 3'd5,
    CMD_READ_ALL   = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_PUT,
    ST_TAKE_RD,
    ST_TAKE,
    ST_DROP,
    ST_EMIT,
    ST_LRD,
    ST_LOUT
  } state_t;

endpackage

FILE: design/bounded_list_with_middle_ops_core.sv
// ---------------------------------------------------------------------------
// bounded_list_with_middle_ops_core
// ordered list of signed values with push/pop at front, back and middle
// ---------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read ram and a small
// sequencer moves entries one at a time through a shared index adder and
// compare. A command is taken only while the core is idle. Every entry that
// has to shift takes one ram read and one ram write. A read-all command
// reads and sends the listed elements one at a time, and it waits whenever
// the sink has not yet taken the previous element. The result sits in an
// output register, so a new command can be taken while the previous result
// still waits for its transfer; a finished command whose result finds that
// register still occupied waits until the sink takes it. The middle element
// is the one at index floor(n/2); a middle push lands right after it, or as
// the only element of an empty list.
`timescale 1ns / 1ps

`include "bounded_list_with_middle_ops_core_defines.svh"

module bounded_list_with_middle_ops_core
  import blmo_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  // command stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // command [2:0], value [34:3], zero pad
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // status [1:0], element [33:2], length [38:34]
  output logic                m_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer state
  state_t state;
  state_t state_next;

  // list bookkeeping
  logic [CW-1:0]    count;     // stored entries
  cmd_t             cmd;       // command in progress
  logic [VAL_W-1:0] val;       // value to insert
  logic [VAL_W-1:0] elem;      // removed value for the result
  status_t          stat;
  logic [AW-1:0]    pos;       // insert or remove position
  logic [AW-1:0]    idx;       // moving cursor

  // output register
  status_t          out_status;
  logic [VAL_W-1:0] out_element;
  logic [LEN_W-1:0] out_length;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  // input decode
  cmd_t             cmd_in;
  logic [VAL_W-1:0] val_in;
  logic             accept;
  logic             full;
  logic             is_push_in;
  logic             is_push;
  logic [AW-1:0]    pos_in;

  // shared index unit
  logic [AW-1:0]    idx_dn;
  logic [AW-1:0]    idx_up;
  logic             out_free;
  logic             list_last;

  assign cmd_in   = cmd_t'(s_tdata[CMD_W-1:0]);
  assign val_in   = s_tdata[CMD_W+VAL_W-1:CMD_W];
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(CAPACITY));
  assign out_free = !m_tvalid || m_tready;

  assign is_push_in = (cmd_in == CMD_PUSH_FRONT) || (cmd_in == CMD_PUSH_BACK) ||
                      (cmd_in == CMD_PUSH_MID);
  assign is_push    = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK) ||
                      (cmd == CMD_PUSH_MID);

  assign idx_dn = idx - AW'(1);
  assign idx_up = idx + AW'(1);

  // last listed element: end of the list or the result limit
  assign list_last = ((CW'(idx) + CW'(1)) == count) || (int'(idx) == MAX_RESULTS - 1);

  // position of the insert or removal, from the length before the command
  always_comb begin
    unique case (cmd_in)
      CMD_PUSH_FRONT: pos_in = '0;
      CMD_PUSH_BACK:  pos_in = AW'(count);
      CMD_PUSH_MID:   pos_in = (count == '0) ? '0 : AW'((count >> 1) + CW'(1));
      CMD_POP_FRONT:  pos_in = '0;
      CMD_POP_BACK:   pos_in = AW'(count - CW'(1));
      CMD_POP_MID:    pos_in = AW'(count >> 1);
      default:        pos_in = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_MID: begin
              if (full) begin
                state_next = ST_EMIT;
              end else if (pos_in == AW'(count)) begin
                state_next = ST_PUT;
              end else begin
                state_next = ST_RD;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              state_next = (count == '0) ? ST_EMIT : ST_TAKE_RD;
            end
            CMD_POP_MID: begin
              state_next = (count < CW'(2)) ? ST_EMIT : ST_TAKE_RD;
            end
            CMD_READ_ALL: begin
              state_next = (count == '0) ? ST_EMIT : ST_LRD;
            end
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_RD: state_next = ST_WR;
      ST_WR: begin
        if (is_push) begin
          state_next = (idx_dn == pos) ? ST_PUT : ST_RD;
        end else begin
          state_next = ((CW'(idx) + CW'(2)) < count) ? ST_RD : ST_DROP;
        end
      end
      ST_PUT:     state_next = ST_EMIT;
      ST_TAKE_RD: state_next = ST_TAKE;
      ST_TAKE:    state_next = ((CW'(pos) + CW'(1)) < count) ? ST_RD : ST_DROP;
      ST_DROP:    state_next = ST_EMIT;
      ST_EMIT:    state_next = out_free ? ST_IDLE : ST_EMIT;
      ST_LRD:     state_next = ST_LOUT;
      ST_LOUT: begin
        if (out_free) begin
          state_next = list_last ? ST_IDLE : ST_LRD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and ram control
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_we    = (state == ST_WR) || (state == ST_PUT);
    ram_waddr = (state == ST_PUT) ? pos : idx;
    ram_wdata = (state == ST_PUT) ? val : ram_rdata;
    unique case (state)
      ST_RD:      ram_raddr = is_push ? idx_dn : idx_up;
      ST_TAKE_RD: ram_raddr = pos;
      default:    ram_raddr = idx;   // list reads hold the address while waiting
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PUT) begin
        count <= count + CW'(1);
      end else if (state == ST_DROP) begin
        count <= count - CW'(1);
      end
      if (((state == ST_EMIT) || (state == ST_LOUT)) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd  <= cmd_in;
          val  <= val_in;
          elem <= '0;
          pos  <= pos_in;
          idx  <= is_push_in ? AW'(count) : '0;
          if (is_push_in) begin
            stat <= full ? STAT_FULL : STAT_OK;
          end else if ((cmd_in == CMD_POP_FRONT) || (cmd_in == CMD_POP_BACK) ||
                       (cmd_in == CMD_READ_ALL)) begin
            stat <= (count == '0) ? STAT_EMPTY : STAT_OK;
          end else if (cmd_in == CMD_POP_MID) begin
            stat <= (count < CW'(2)) ? STAT_EMPTY : STAT_OK;
          end else begin
            stat <= STAT_EMPTY;   // unknown command is ignored
          end
        end
      end
      ST_WR: idx <= is_push ? idx_dn : idx_up;
      ST_TAKE: begin
        elem <= ram_rdata;
        idx  <= pos;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_status  <= stat;
          out_element <= elem;
          out_length  <= LEN_W'(count);
          m_tlast     <= 1'b1;
        end
      end
      ST_LOUT: begin
        if (out_free) begin
          out_status  <= STAT_OK;
          out_element <= ram_rdata;
          out_length  <= LEN_W'(count);
          m_tlast     <= list_last;
          idx         <= idx_up;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {{(M_DATA_W - STAT_W - VAL_W - LEN_W){1'b0}},
                    out_length, out_element, out_status};

  // list storage
  blmo_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // checks
  `BLMO_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `BLMO_ASSERT_NXT(a_full_drop, clk, rst, accept && is_push_in && full, (state == ST_EMIT) && (stat == STAT_FULL))
  `BLMO_ASSERT_NXT(a_shift_keeps_count, clk, rst, (state == ST_RD) || (state == ST_WR), $stable(count))

endmodule

FILE: design/blmo_ram.sv
// ---------------------------------------------------------------------------
// blmo_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blmo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
